>>> design/mptw_pkg.sv
`default_nettype none

package mptw_pkg;

    localparam int OFFSET_BITS = 12;
    localparam int LEVEL_COUNT = 4;
    localparam int FRAME_COUNT = 256;

    localparam int INDEX_BITS  = OFFSET_BITS - 3;
    localparam int FRAME_BITS  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int FREE_W      = FRAME_BITS + 1;
    localparam int ENTRY_W     = FRAME_BITS + 1;
    localparam int ADDR_W      = FRAME_BITS + INDEX_BITS;
    localparam int STORE_DEPTH = FRAME_COUNT * (2 ** INDEX_BITS);
    localparam int LEVEL_W     = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
    localparam int VPN_W       = LEVEL_COUNT * INDEX_BITS;

    localparam int VA_W        = 48;
    localparam int PA_W        = 20;
    localparam int STATUS_W    = 2;
    localparam int CMD_W       = 1;
    localparam int S_TDATA_W   = ((VA_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((PA_W + STATUS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_TRANSLATE = 1'b0,
        CMD_ALLOCATE  = 1'b1
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FAULT    = 2'd1,
        STATUS_NO_FRAME = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic    accept;
        logic    clear;
        logic    root_take;
        logic    follow;
        logic    fill;
        logic    res_load;
        status_t res_status;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic cmd_alloc;
        logic root_present;
        logic pool_empty;
        logic entry_valid;
        logic last_level;
        logic clear_done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> design/mptw_ram.sv
`default_nettype none

module mptw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/mptw_datapath.sv
`default_nettype none

module mptw_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire mptw_pkg::dp_cmd_t                 cmd,
    output mptw_pkg::dp_stat_t                     stat,
    input  wire logic [mptw_pkg::S_TDATA_W-1:0]    in_data,
    input  wire logic [mptw_pkg::CMD_W-1:0]        in_user,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic      [mptw_pkg::M_TDATA_W-1:0]    out_data
);

    localparam int PA_FULL_W = mptw_pkg::FRAME_BITS + mptw_pkg::OFFSET_BITS;

    mptw_pkg::command_t                       cmd_reg;
    logic [mptw_pkg::VPN_W-1:0]               vpn_reg;
    logic [mptw_pkg::OFFSET_BITS-1:0]         offset_reg;
    logic [mptw_pkg::FRAME_BITS-1:0]          table_reg;
    logic [mptw_pkg::LEVEL_W-1:0]             level_reg;
    mptw_pkg::status_t                        status_reg;
    logic [mptw_pkg::PA_W-1:0]                out_pa_reg;
    mptw_pkg::status_t                        out_status_reg;

    logic [mptw_pkg::FREE_W-1:0]              free_reg;
    logic                                     root_reg;
    logic [mptw_pkg::ADDR_W-1:0]              clr_reg;
    logic                                     out_valid_reg;

    logic [mptw_pkg::VA_W-1:0]                va;
    logic [mptw_pkg::VA_W+mptw_pkg::VPN_W-1:0] va_ext;
    logic [mptw_pkg::ADDR_W-1:0]              slot;
    logic [mptw_pkg::FRAME_BITS-1:0]          fresh;
    logic                                     ram_we;
    logic [mptw_pkg::ADDR_W-1:0]              ram_waddr;
    logic [mptw_pkg::ENTRY_W-1:0]             ram_wdata;
    logic [mptw_pkg::ENTRY_W-1:0]             ram_rdata;
    logic [mptw_pkg::FRAME_BITS-1:0]          entry_frame;
    logic [PA_FULL_W-1:0]                     pa_full;
    logic [PA_FULL_W+mptw_pkg::PA_W-1:0]      pa_ext;
    logic [mptw_pkg::PA_W-1:0]                pa_result;

    assign va          = in_data[mptw_pkg::VA_W-1:0];
    assign va_ext      = {{mptw_pkg::VPN_W{1'b0}}, va};
    assign slot        = {table_reg, vpn_reg[mptw_pkg::VPN_W-1 -: mptw_pkg::INDEX_BITS]};
    assign fresh       = free_reg[mptw_pkg::FRAME_BITS-1:0];
    assign entry_frame = ram_rdata[mptw_pkg::ENTRY_W-1:1];

    assign ram_we    = cmd.clear | cmd.fill;
    assign ram_waddr = cmd.clear ? clr_reg : slot;
    assign ram_wdata = cmd.clear ? '0 : {fresh, 1'b1};

    mptw_ram #(
        .WIDTH(mptw_pkg::ENTRY_W),
        .DEPTH(mptw_pkg::STORE_DEPTH)
    ) u_table_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(slot),
        .rdata(ram_rdata)
    );

    assign pa_full   = {table_reg, offset_reg};
    assign pa_ext    = {{mptw_pkg::PA_W{1'b0}}, pa_full};
    assign pa_result = (status_reg == mptw_pkg::STATUS_OK && cmd_reg == mptw_pkg::CMD_TRANSLATE)
                       ? pa_ext[mptw_pkg::PA_W-1:0] : '0;

    always_comb
    begin
        stat.cmd_alloc    = (cmd_reg == mptw_pkg::CMD_ALLOCATE);
        stat.root_present = root_reg;
        stat.pool_empty   = (free_reg == mptw_pkg::FREE_W'(mptw_pkg::FRAME_COUNT));
        stat.entry_valid  = ram_rdata[0];
        stat.last_level   = (level_reg == mptw_pkg::LEVEL_W'(mptw_pkg::LEVEL_COUNT - 1));
        stat.clear_done   = (clr_reg == mptw_pkg::ADDR_W'(mptw_pkg::STORE_DEPTH - 1));
        stat.out_free     = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg      <= '0;
            root_reg      <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + mptw_pkg::ADDR_W'(1);
            end
            if (cmd.root_take)
            begin
                root_reg <= 1'b1;
            end
            if (cmd.root_take || cmd.fill)
            begin
                free_reg <= free_reg + mptw_pkg::FREE_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg    <= mptw_pkg::command_t'(in_user);
            vpn_reg    <= va_ext[mptw_pkg::OFFSET_BITS +: mptw_pkg::VPN_W];
            offset_reg <= va[mptw_pkg::OFFSET_BITS-1:0];
            table_reg  <= '0;
            level_reg  <= '0;
        end
        else if (cmd.follow || cmd.fill)
        begin
            table_reg <= cmd.fill ? fresh : entry_frame;
            vpn_reg   <= vpn_reg << mptw_pkg::INDEX_BITS;
            level_reg <= level_reg + mptw_pkg::LEVEL_W'(1);
        end
        if (cmd.res_load)
        begin
            status_reg <= cmd.res_status;
        end
        if (cmd.out_load)
        begin
            out_pa_reg     <= pa_result;
            out_status_reg <= status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = mptw_pkg::M_TDATA_W'({out_status_reg, out_pa_reg});

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= mptw_pkg::FREE_W'(mptw_pkg::FRAME_COUNT))
        else $error("frame counter beyond pool size");

    a_fill_has_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill |-> !stat.pool_empty)
        else $error("fill with empty pool");

    a_follow_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.follow |-> ({1'b0, entry_frame} < free_reg))
        else $error("entry points at a frame never taken");

    a_root_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(root_reg))
        else $error("root table lost");

endmodule

`default_nettype wire

>>> design/mptw_ctrl.sv
`default_nettype none

module mptw_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire mptw_pkg::dp_stat_t stat,
    output mptw_pkg::dp_cmd_t       cmd
);

    mptw_pkg::state_t state_reg;
    mptw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mptw_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.res_status = mptw_pkg::STATUS_OK;
        in_ready       = 1'b0;
        case (state_reg)
            mptw_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = mptw_pkg::ST_IDLE;
                end
            end
            mptw_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = mptw_pkg::ST_START;
                end
            end
            mptw_pkg::ST_START:
            begin
                if (stat.root_present)
                begin
                    state_next = mptw_pkg::ST_READ;
                end
                else if (!stat.cmd_alloc)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = mptw_pkg::STATUS_FAULT;
                    state_next     = mptw_pkg::ST_FINISH;
                end
                else if (stat.pool_empty)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = mptw_pkg::STATUS_NO_FRAME;
                    state_next     = mptw_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.root_take = 1'b1;
                    state_next    = mptw_pkg::ST_READ;
                end
            end
            mptw_pkg::ST_READ:
            begin
                state_next = mptw_pkg::ST_CHECK;
            end
            mptw_pkg::ST_CHECK:
            begin
                if (stat.entry_valid || (stat.cmd_alloc && !stat.pool_empty))
                begin
                    cmd.follow = stat.entry_valid;
                    cmd.fill   = !stat.entry_valid;
                    if (stat.last_level)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = mptw_pkg::STATUS_OK;
                        state_next     = mptw_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = mptw_pkg::ST_READ;
                    end
                end
                else
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = stat.cmd_alloc ? mptw_pkg::STATUS_NO_FRAME
                                                    : mptw_pkg::STATUS_FAULT;
                    state_next     = mptw_pkg::ST_FINISH;
                end
            end
            mptw_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = mptw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mptw_pkg::ST_IDLE;
            end
        endcase
    end

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == mptw_pkg::ST_START)
        else $error("accepted item did not start a walk");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mptw_pkg::ST_CLEAR |-> !in_ready && !cmd.fill && !cmd.root_take)
        else $error("activity during clearing pass");

    a_one_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.clear, cmd.fill, cmd.root_take}) <= 1)
        else $error("conflicting table updates");

endmodule

`default_nettype wire

>>> design/multilevel_page_table_walker.sv
// Walk: an accepted input transfer passes ST_START, then ST_READ and ST_CHECK once per level,
// then ST_FINISH, which loads the registered output; a walk that faults or finds the pool
// dry ends early, and ST_FINISH waits while m_axis_tready is low. The single walk unit takes
// a new item only after the last one has left ST_FINISH; a full walk does one table memory
// read and check per level. Reset: asynchronous; afterwards a clearing pass zeroes all
// FRAME_COUNT*2^(OFFSET_BITS-3) table memory entries (131072) with s_axis_tready low.
`default_nettype none

module multilevel_page_table_walker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [mptw_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // virtual_address
    input  wire logic [mptw_pkg::CMD_W-1:0]        s_axis_tuser,  // command
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic      [mptw_pkg::M_TDATA_W-1:0]    m_axis_tdata   // physical_address, status
);

    mptw_pkg::dp_cmd_t  cmd;
    mptw_pkg::dp_stat_t stat;

    mptw_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mptw_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_data  (s_axis_tdata),
        .in_user  (s_axis_tuser),
        .out_ready(m_axis_tready),
        .out_valid(m_axis_tvalid),
        .out_data (m_axis_tdata)
    );

endmodule

`default_nettype wire
